// File: hw/rtl/sfpr_pkg.sv
// shared types and constants for the framed page receiver
package sfpr_pkg;

    localparam logic [1:0] RESP_OK   = 2'd0;
    localparam logic [1:0] RESP_FAIL = 2'd1;
    localparam logic [1:0] RESP_BUSY = 2'd2;

    localparam logic KIND_PAYLOAD  = 1'b0;
    localparam logic KIND_RESPONSE = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       power_output_on;
    } rx_item_t;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_offset;
        logic [1:0]  response_code;
        logic [9:0]  page_address;
        logic [15:0] crc_received;
        logic [15:0] crc_computed;
        logic [15:0] good_frame_total;
        logic [15:0] error_total;
    } res_item_t;

    // classified item handed from the parser to the response stage
    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic [7:0]  offset;
        logic [9:0]  page_idx;
        logic [15:0] crc_rx;
        logic [15:0] crc_calc;
        logic        fail;
        logic        power_on;
    } frame_rec_t;

endpackage

// File: hw/rtl/sfpr_front.sv
// frame parser: sync search, page index, payload offsets and running crc
module sfpr_front
    import sfpr_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 256,
    parameter int PAGE_COUNT    = 1024
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  rx_item_t   rx_item,
    input  logic       q_full,
    output logic       push,
    output frame_rec_t rec
);

    localparam logic [7:0]  SYNC_A   = 8'hAA;
    localparam logic [7:0]  SYNC_B   = 8'h55;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [2:0] {
        PH_SYNC0,
        PH_SYNC1,
        PH_PAGE0,
        PH_PAGE1,
        PH_DATA,
        PH_CRC0,
        PH_CRC1
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [8:0]  count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] page_reg, page_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;

    logic        accept;
    logic [7:0]  b;
    logic [15:0] crc_step_val;
    logic [15:0] frame_crc;
    logic [8:0]  count_inc;
    logic        fail;

    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] v);
        logic [15:0] r;
        r = c ^ {v, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (r[15])
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            else
                r = {r[14:0], 1'b0};
        end
        return r;
    endfunction

    assign rx_stall     = q_full;
    assign accept       = rx_valid && !q_full;
    assign b            = rx_item.rx_byte;
    assign crc_step_val = crc_step((phase_reg == PH_PAGE0) ? 16'h0000 : crc_reg, b);
    assign frame_crc    = {b, crc_lo_reg};
    assign count_inc    = count_reg + 9'd1;
    assign fail         = (page_reg >= 16'(PAGE_COUNT)) || (crc_reg != frame_crc);

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        crc_next    = crc_reg;
        page_next   = page_reg;
        crc_lo_next = crc_lo_reg;
        unique case (phase_reg)
            PH_SYNC0:
            begin
                if (b == SYNC_A)
                    phase_next = PH_SYNC1;
            end
            PH_SYNC1:
            begin
                if (b == SYNC_B)
                begin
                    phase_next = PH_PAGE0;
                    crc_next   = 16'h0000;
                end
                else if (b == SYNC_A)
                    phase_next = PH_SYNC1;
                else
                    phase_next = PH_SYNC0;
            end
            PH_PAGE0:
            begin
                page_next  = {8'h00, b};
                crc_next   = crc_step_val;
                phase_next = PH_PAGE1;
            end
            PH_PAGE1:
            begin
                page_next  = {b, page_reg[7:0]};
                crc_next   = crc_step_val;
                count_next = 9'd0;
                phase_next = PH_DATA;
            end
            PH_DATA:
            begin
                crc_next   = crc_step_val;
                count_next = count_inc;
                if (count_inc >= 9'(PAYLOAD_BYTES))
                    phase_next = PH_CRC0;
            end
            PH_CRC0:
            begin
                crc_lo_next = b;
                phase_next  = PH_CRC1;
            end
            PH_CRC1:
            begin
                crc_lo_next = b;
                // a failed frame resyncs on its last byte
                if (fail && b == SYNC_A)
                    phase_next = PH_SYNC1;
                else
                    phase_next = PH_SYNC0;
            end
            default:
            begin
                phase_next = (b == SYNC_A) ? PH_SYNC1 : PH_SYNC0;
            end
        endcase
    end

    assign push = accept && (phase_reg == PH_DATA || phase_reg == PH_CRC1);

    always_comb
    begin
        rec.kind     = (phase_reg == PH_CRC1) ? KIND_RESPONSE : KIND_PAYLOAD;
        rec.data     = b;
        rec.offset   = count_reg[7:0];
        rec.page_idx = page_reg[9:0];
        rec.crc_rx   = frame_crc;
        rec.crc_calc = crc_reg;
        rec.fail     = fail;
        rec.power_on = rx_item.power_output_on;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SYNC0;
            count_reg  <= 9'd0;
            crc_reg    <= 16'h0000;
            page_reg   <= 16'h0000;
            crc_lo_reg <= 8'h00;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            crc_reg    <= crc_next;
            page_reg   <= page_next;
            crc_lo_reg <= crc_lo_next;
        end
    end

endmodule

// File: hw/rtl/sfpr_queue.sv
// short fifo between the parser and the response stage
module sfpr_queue
    import sfpr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  frame_rec_t push_rec,
    output logic       full,
    input  logic       pop,
    output logic       not_empty,
    output frame_rec_t pop_rec
);

    frame_rec_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg;
    logic [QPTR_W-1:0]     rd_ptr_reg;
    logic [QPTR_W:0]       fill_reg;

    assign full      = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign pop_rec   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                fill_reg <= fill_reg + (QPTR_W+1)'(1);
            else if (pop && !push)
                fill_reg <= fill_reg - (QPTR_W+1)'(1);
        end
    end

endmodule

// File: hw/rtl/sfpr_back.sv
// response stage: verdict, frame counters and output register
module sfpr_back
    import sfpr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_not_empty,
    input  frame_rec_t q_rec,
    output logic       q_pop,
    output logic       res_valid,
    input  logic       res_stall,
    output res_item_t  res_item
);

    logic        out_valid_reg;
    res_item_t   out_item_reg, out_item_next;
    logic [15:0] good_reg, good_next;
    logic [15:0] bad_reg, bad_next;
    logic [1:0]  code;

    assign q_pop = q_not_empty && (!out_valid_reg || !res_stall);

    always_comb
    begin
        good_next     = good_reg;
        bad_next      = bad_reg;
        code          = RESP_OK;
        out_item_next = '0;
        if (q_rec.kind == KIND_RESPONSE)
        begin
            if (q_rec.fail)
            begin
                code     = RESP_FAIL;
                bad_next = bad_reg + 16'd1;
            end
            else if (q_rec.power_on)
                code = RESP_BUSY;
            else
            begin
                code      = RESP_OK;
                good_next = good_reg + 16'd1;
            end
            out_item_next.item_kind        = KIND_RESPONSE;
            out_item_next.response_code    = code;
            out_item_next.page_address     = q_rec.page_idx;
            out_item_next.crc_received     = q_rec.crc_rx;
            out_item_next.crc_computed     = q_rec.crc_calc;
            out_item_next.good_frame_total = good_next;
            out_item_next.error_total      = bad_next;
        end
        else
        begin
            out_item_next.item_kind      = KIND_PAYLOAD;
            out_item_next.payload_byte   = q_rec.data;
            out_item_next.payload_offset = q_rec.offset;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            good_reg      <= 16'd0;
            bad_reg       <= 16'd0;
        end
        else
        begin
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
                good_reg      <= good_next;
                bad_reg       <= bad_next;
            end
            else if (!res_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            out_item_reg <= out_item_next;
    end

    assign res_valid = out_valid_reg;
    assign res_item  = out_item_reg;

endmodule

// File: hw/rtl/sync_framed_page_receiver_crc16_unit.sv
// top level of the framed page receiver with crc16 check
// usage:
//   rx channel (rx_valid, rx_stall, rx_item) takes one serial byte per transfer
//   together with the power output flag sampled for that byte.
//   res channel (res_valid, res_stall, res_item) gives one item for each
//   payload byte (byte and offset) and one response after the last crc byte.
//   sync, page index and crc bytes give no item.
// flow: a result passes through the queue and then the output register before
//   it is offered; the parser takes one byte per cycle while the queue is not
//   full and the output stage gives one item per cycle while res_stall is low,
//   so a steady stream runs at one byte per cycle when neither side stalls.
// the crc update of one byte is done in the parser in the cycle the byte
//   arrives; a four entry queue sits between parser and response stage.
// reset: frame search restarts at the first sync byte, counters and crc clear,
//   the queue and the output register empty.
// stall: while res_stall is high the output item holds; the queue fills and
//   rx_stall rises once it holds four items, and the input side is then held
//   off until the queue drains.
module sync_framed_page_receiver_crc16_unit
    import sfpr_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 256,
    parameter int PAGE_COUNT    = 1024
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      rx_valid,
    output logic      rx_stall,
    input  rx_item_t  rx_item,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res_item
);

    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_not_empty;
    frame_rec_t push_rec;
    frame_rec_t pop_rec;

    sfpr_front #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .PAGE_COUNT    (PAGE_COUNT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_stall (rx_stall),
        .rx_item  (rx_item),
        .q_full   (q_full),
        .push     (push),
        .rec      (push_rec)
    );

    sfpr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (push_rec),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .pop_rec   (pop_rec)
    );

    sfpr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_rec       (pop_rec),
        .q_pop       (pop),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res_item    (res_item)
    );

endmodule

// File: hw/rtl/sfpr_checker.sv
// port level checks for the framed page receiver
module sfpr_checker
    import sfpr_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      rx_valid,
    input logic      rx_stall,
    input logic      res_valid,
    input logic      res_stall,
    input res_item_t res_item
);

    a_rx_stall_known: assert property (@(posedge clk) disable iff (!rst_n)
        rx_valid |-> !$isunknown(rx_stall))
        else $error("input stall unknown");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(res_item))
        else $error("stalled result changed");

    a_resp_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.item_kind == KIND_RESPONSE |->
            res_item.response_code == RESP_OK || res_item.response_code == RESP_FAIL ||
            res_item.response_code == RESP_BUSY)
        else $error("bad response code");

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.item_kind == KIND_PAYLOAD |->
            res_item.response_code == RESP_OK && res_item.good_frame_total == 16'd0 &&
            res_item.error_total == 16'd0 && res_item.crc_computed == 16'd0)
        else $error("payload item carries response fields");

endmodule

bind sync_framed_page_receiver_crc16_unit sfpr_checker u_sfpr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rx_valid  (rx_valid),
    .rx_stall  (rx_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
);
